/* hw/rtl/aspof_pkg.sv */
package aspof_pkg;

  // Parser phases within one attribute.
  localparam logic [1:0] PH_TYPE  = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_ASN   = 2'd2;

  // Verdict codes on the result channel.
  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_REJECT    = 2'd1;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd2;

  // Index of the last byte of a 4-byte AS number.
  localparam logic [1:0] ASN_LAST_BYTE = 2'd3;

endpackage

/* hw/rtl/as_path_origin_parity_filter_top.sv */
// Channel   Direction  Handshake                   Payload
// byte      in         byte_valid / byte_stall     data_byte[7:0], last_byte
// result    out        result_valid / result_stall verdict[1:0], origin_asn[31:0]
//
// One attribute byte is taken per cycle while byte_stall is low.
// The parser state and a single result register are the only storage, so a
// verdict appears in the cycle after its last byte is accepted.
// The byte channel stalls only while a verdict waits and the result side stalls.
// Reset (rst, synchronous, active high) clears the parser and drops result_valid.
// After each verdict the parser returns to its reset state for the next attribute.
module as_path_origin_parity_filter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  verdict,
  output logic [31:0] origin_asn
);

  // Parser state.
  logic [1:0]  parse_phase, parse_phase_next;
  logic [7:0]  asns_left, asns_left_next;
  logic [1:0]  byte_in_asn, byte_in_asn_next;
  logic [31:0] asn_shift, asn_shift_next;
  logic [31:0] last_asn, last_asn_next;
  logic        seen_asn, seen_asn_next;

  logic        byte_take;
  logic        result_take;
  logic [31:0] asn_shifted;
  logic [7:0]  asns_dec;
  logic        malformed;
  logic [1:0]  verdict_next;

  // A new transaction is taken whenever the result register is free or is
  // being emptied in the same cycle.
  assign byte_stall  = result_valid && result_stall;
  assign byte_take   = byte_valid && !byte_stall;
  assign result_take = result_valid && !result_stall;

  assign asn_shifted = {asn_shift[23:0], data_byte};
  assign asns_dec    = asns_left - 8'd1;

  // Next parser state for the byte on the input.
  always_comb begin
    parse_phase_next = parse_phase;
    asns_left_next   = asns_left;
    byte_in_asn_next = byte_in_asn;
    asn_shift_next   = asn_shift;
    last_asn_next    = last_asn;
    seen_asn_next    = seen_asn;
    case (parse_phase)
      aspof_pkg::PH_COUNT: begin
        // The count byte opens a segment; a zero count is a valid empty segment.
        asns_left_next   = data_byte;
        byte_in_asn_next = 2'd0;
        asn_shift_next   = 32'd0;
        parse_phase_next = (data_byte != 8'd0) ? aspof_pkg::PH_ASN : aspof_pkg::PH_TYPE;
      end
      aspof_pkg::PH_ASN: begin
        if (byte_in_asn == aspof_pkg::ASN_LAST_BYTE) begin
          // The fourth byte completes a big-endian AS number.
          last_asn_next    = asn_shifted;
          seen_asn_next    = 1'b1;
          byte_in_asn_next = 2'd0;
          asn_shift_next   = 32'd0;
          asns_left_next   = asns_dec;
          if (asns_dec == 8'd0) begin
            parse_phase_next = aspof_pkg::PH_TYPE;
          end
        end else begin
          asn_shift_next   = asn_shifted;
          byte_in_asn_next = byte_in_asn + 2'd1;
        end
      end
      default: begin
        // The segment type byte carries nothing we use; the unused phase
        // code behaves the same way.
        parse_phase_next = aspof_pkg::PH_COUNT;
      end
    endcase
  end

  // The attribute is cut short if it ends anywhere but a segment boundary.
  assign malformed = (parse_phase_next != aspof_pkg::PH_TYPE);

  always_comb begin
    if (malformed || !seen_asn_next) begin
      verdict_next = aspof_pkg::VERDICT_MALFORMED;
    end else if (last_asn_next[0]) begin
      verdict_next = aspof_pkg::VERDICT_REJECT;
    end else begin
      verdict_next = aspof_pkg::VERDICT_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= aspof_pkg::PH_TYPE;
      asns_left   <= 8'd0;
      byte_in_asn <= 2'd0;
      asn_shift   <= 32'd0;
      last_asn    <= 32'd0;
      seen_asn    <= 1'b0;
    end else if (byte_take) begin
      if (last_byte) begin
        // The verdict closes the attribute and the parser starts over.
        parse_phase <= aspof_pkg::PH_TYPE;
        asns_left   <= 8'd0;
        byte_in_asn <= 2'd0;
        asn_shift   <= 32'd0;
        last_asn    <= 32'd0;
        seen_asn    <= 1'b0;
      end else begin
        parse_phase <= parse_phase_next;
        asns_left   <= asns_left_next;
        byte_in_asn <= byte_in_asn_next;
        asn_shift   <= asn_shift_next;
        last_asn    <= last_asn_next;
        seen_asn    <= seen_asn_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (byte_take && last_byte) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && last_byte) begin
      verdict    <= verdict_next;
      origin_asn <= last_asn_next;
    end
  end

  // A last byte always yields a verdict in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    byte_take && last_byte |=> result_valid)
    else $error("last byte accepted without a verdict");

  // Accept and reject follow the parity of the reported AS number.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (verdict != aspof_pkg::VERDICT_MALFORMED) |->
      (verdict == {1'b0, origin_asn[0]}))
    else $error("verdict does not match origin AS parity");

  // The saved AS number stays zero until one has been completed.
  assert property (@(posedge clk) disable iff (rst)
    !seen_asn |-> (last_asn == 32'd0))
    else $error("AS number held without one being seen");

  // A segment in progress always has AS numbers still due.
  assert property (@(posedge clk) disable iff (rst)
    (parse_phase == aspof_pkg::PH_ASN) |-> (asns_left != 8'd0))
    else $error("AS phase with no AS numbers left");

endmodule

/* dv/tb_as_path_origin_parity_filter_top.sv */
`timescale 1ns / 100ps

module tb_as_path_origin_parity_filter_top;

  // One verdict as it leaves the block on the result channel.
  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] origin_asn;
  } path_verdict_t;

  // The scoreboard walks the AS_PATH bytes itself. Each accepted byte moves
  // its own copy of the parser state. A byte that carries the last-byte mark
  // turns that state into the verdict the block must give for the attribute.
  class as_path_verdict_board;
    logic [1:0]    phase;
    logic [7:0]    asns_left;
    logic [1:0]    byte_in_asn;
    logic [31:0]   asn_shift;
    logic [31:0]   last_asn;
    bit            seen_asn;
    path_verdict_t expected_verdicts[$];
    int            errors;

    function new();
      errors = 0;
      clear_path();
    endfunction

    function void clear_path();
      phase       = aspof_pkg::PH_TYPE;
      asns_left   = '0;
      byte_in_asn = '0;
      asn_shift   = '0;
      last_asn    = '0;
      seen_asn    = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      path_verdict_t v;
      case (phase)
        aspof_pkg::PH_COUNT: begin
          asns_left   = b;
          byte_in_asn = '0;
          asn_shift   = '0;
          phase       = (b != 8'd0) ? aspof_pkg::PH_ASN : aspof_pkg::PH_TYPE;
        end
        aspof_pkg::PH_ASN: begin
          asn_shift = {asn_shift[23:0], b};
          if (byte_in_asn == aspof_pkg::ASN_LAST_BYTE) begin
            last_asn    = asn_shift;
            seen_asn    = 1;
            byte_in_asn = '0;
            asn_shift   = '0;
            asns_left   = asns_left - 8'd1;
            if (asns_left == 8'd0) phase = aspof_pkg::PH_TYPE;
          end else begin
            byte_in_asn = byte_in_asn + 2'd1;
          end
        end
        default: phase = aspof_pkg::PH_COUNT;
      endcase
      if (fin) begin
        if (phase != aspof_pkg::PH_TYPE || !seen_asn) begin
          v.verdict = aspof_pkg::VERDICT_MALFORMED;
        end else begin
          v.verdict = last_asn[0] ? aspof_pkg::VERDICT_REJECT : aspof_pkg::VERDICT_ACCEPT;
        end
        v.origin_asn = last_asn;
        expected_verdicts.push_back(v);
        clear_path();
      end
    endfunction

    function void check_result(logic [1:0] verdict, logic [31:0] origin_asn);
      path_verdict_t v;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: verdict=%0d origin_asn=%h", verdict, origin_asn);
        errors++;
        return;
      end
      v = expected_verdicts.pop_front();
      if (verdict !== v.verdict) begin
        $error("verdict: expected %0d, actual %0d", v.verdict, verdict);
        errors++;
      end
      if (origin_asn !== v.origin_asn) begin
        $error("origin_asn: expected %h, actual %h", v.origin_asn, origin_asn);
        errors++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        result_valid;
  logic        result_stall;
  logic [1:0]  verdict;
  logic [31:0] origin_asn;

  as_path_verdict_board board;

  // Bytes of the attribute about to be sent, first byte at the front.
  logic [7:0] attr_bytes[$];
  int         bytes_sent;
  // Sender pacing: a burst runs for burst_left bytes, then a gap may follow.
  int         burst_left;
  bit         sender_gappy;
  // Receiver stall pattern, redrawn at random as the run goes on.
  int         stall_mode;
  int         cycle_count;

  as_path_origin_parity_filter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict),
    .origin_asn   (origin_asn)
  );

  always #2 clk = ~clk;

  // The receiver stalls on a pattern of its own. Mode 0 never stalls, so
  // there are stretches where the byte channel runs at full rate; the other
  // modes make light, heavy and periodic back pressure.
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) stall_mode <= int'($urandom_range(0, 3));
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 1) == 0);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= (cycle_count % 7 < 3);
      endcase
    end
  end

  // A result transaction completes at a rising edge with valid high and
  // stall low. Outputs and stall are read here before the edge's updates land.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      board.check_result(verdict, origin_asn);
  end

  // Hold the byte channel idle; the payload is noise meanwhile.
  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      byte_valid <= 1'b0;
      data_byte  <= 8'($urandom_range(0, 255));
      last_byte  <= 1'($urandom_range(0, 1));
    end
  endtask

  // Present one byte and hold it until the block takes it. The byte is handed
  // to the scoreboard only once the transaction has completed.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      if (sender_gappy) idle_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= fin;
    do @(posedge clk); while (byte_stall);
    board.note_byte(b, fin);
    bytes_sent++;
  endtask

  // Send attr_bytes as one attribute; the mark goes on its final byte.
  task automatic send_attribute();
    for (int i = 0; i < attr_bytes.size(); i++)
      send_byte(attr_bytes[i], i == attr_bytes.size() - 1);
  endtask

  // AS numbers lean toward the all-zero and all-one extremes now and then.
  function automatic logic [31:0] pick_asn();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0000_0000;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Append one segment: a type byte, the count, then count AS numbers.
  function automatic void add_segment(input logic [7:0] count);
    logic [31:0] asn;
    attr_bytes.push_back(8'($urandom_range(0, 255)));
    attr_bytes.push_back(count);
    for (int i = 0; i < count; i++) begin
      asn = pick_asn();
      attr_bytes.push_back(asn[31:24]);
      attr_bytes.push_back(asn[23:16]);
      attr_bytes.push_back(asn[15:8]);
      attr_bytes.push_back(asn[7:0]);
    end
  endfunction

  // Counts are mostly small so that most attributes finish cleanly; a few
  // are long enough to run the AS counter through many values.
  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 96) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(4, 40));
  endfunction

  initial begin
    int kind;
    int limit;
    clk          = 1'b0;
    rst          = 1'b1;
    byte_valid   = 1'b0;
    data_byte    = 8'h00;
    last_byte    = 1'b0;
    result_stall = 1'b0;
    stall_mode   = 0;
    cycle_count  = 1;
    bytes_sent   = 0;
    burst_left   = 0;
    sender_gappy = 0;
    board        = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed attributes.
    // A single AS number with every bit set gives an odd origin.
    attr_bytes = '{8'h02, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_attribute();
    // The attribute ends right after a type byte, so the count is missing.
    attr_bytes = '{8'h02};
    send_attribute();
    // A zero-count segment is legal, but with no AS number seen the path
    // is still malformed.
    attr_bytes = '{8'h00, 8'h00};
    send_attribute();
    // Count of 255 and an AS number cut off after one byte, none complete.
    attr_bytes = '{8'hFF, 8'hFF, 8'h00};
    send_attribute();
    // An even AS number followed by an empty segment is accepted.
    attr_bytes = '{8'h01, 8'h01, 8'h80, 8'h00, 8'h00, 8'h02, 8'h03, 8'h00};
    send_attribute();
    // A complete AS number, then the attribute ends with a second one still
    // due; the origin is the last complete one.
    attr_bytes = '{8'h02, 8'h02, 8'h12, 8'h34, 8'h56, 8'h78};
    send_attribute();

    // Random attributes. Most are well formed with random content; the
    // rest are cut short at a random point or are plain noise.
    while (bytes_sent < 1600) begin
      if ($urandom_range(0, 19) == 0) sender_gappy = 1'($urandom_range(0, 1));
      attr_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        repeat ($urandom_range(1, 3)) add_segment(pick_count());
      end else if (kind < 88) begin
        // Any count value at all, then truncated.
        add_segment(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) add_segment(pick_count());
        limit = $urandom_range(1, 30);
        while (attr_bytes.size() > limit) void'(attr_bytes.pop_back());
      end else begin
        repeat ($urandom_range(1, 10)) attr_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_attribute();
    end

    @(negedge clk);
    byte_valid <= 1'b0;

    // Drain outstanding verdicts, then idle so that any stray one is still seen.
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
